>>> rtl/bbts_pkg.sv
// Package: shared constants, codes and control types of the boundary transfer splitter.
`default_nettype none
package bbts_pkg;

   localparam int BLOCK_SIZE = 256;
   localparam int MAX_LENGTH = 7936;

   localparam int ADDR_W = 48;
   localparam int LEN_W  = 13;
   localparam int KIND_W = 3;
   localparam int BYTE_W = 8;
   localparam int OFS_W  = $clog2(BLOCK_SIZE);
   localparam int ROOM_W = OFS_W + 1;

   localparam logic REQ_FILL = 1'b0;
   localparam logic REQ_COPY = 1'b1;

   localparam logic [KIND_W-1:0] KIND_HOST_HOST = 3'd0;
   localparam logic [KIND_W-1:0] KIND_HOST_DEV  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DEV_HOST  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DEV_DEV   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DEFAULT   = 3'd4;

   // How the current request is cut into chunks
   typedef enum logic [1:0] {
      MODE_REJECT = 2'd0,
      MODE_WHOLE  = 2'd1,
      MODE_BOTH   = 2'd2,
      MODE_DEV    = 2'd3
   } mode_type;

   typedef struct packed {
      logic load;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic nothing_left;
      logic chunk_last;
      logic slot_free;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/bbts_req_if.sv
// Interface: request channel carrying one fill or copy request word.
`default_nettype none
interface bbts_req_if;
   import bbts_pkg::*;

   logic                valid;
   logic                ready;
   logic                req_type;
   logic [KIND_W-1:0]   copy_kind;
   logic [ADDR_W-1:0]   dest_addr;
   logic [ADDR_W-1:0]   source_addr;
   logic [LEN_W-1:0]    byte_length;
   logic [BYTE_W-1:0]   fill_byte;
   logic [BYTE_W-1:0]   stream_tag;

   modport source (
      output valid, req_type, copy_kind, dest_addr, source_addr, byte_length,
             fill_byte, stream_tag,
      input  ready
   );

   modport sink (
      input  valid, req_type, copy_kind, dest_addr, source_addr, byte_length,
             fill_byte, stream_tag,
      output ready
   );
endinterface
`default_nettype wire

>>> rtl/bbts_rsp_if.sv
// Interface: response channel carrying one chunk word.
`default_nettype none
interface bbts_rsp_if;
   import bbts_pkg::*;

   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   chunk_dest;
   logic [ADDR_W-1:0]   chunk_source;
   logic [LEN_W-1:0]    chunk_length;
   logic                chunk_is_copy;
   logic [KIND_W-1:0]   chunk_kind;
   logic [BYTE_W-1:0]   chunk_fill;
   logic [BYTE_W-1:0]   chunk_stream;
   logic                last_chunk;
   logic                rejected;

   modport source (
      output valid, chunk_dest, chunk_source, chunk_length, chunk_is_copy, chunk_kind,
             chunk_fill, chunk_stream, last_chunk, rejected,
      input  ready
   );

   modport sink (
      input  valid, chunk_dest, chunk_source, chunk_length, chunk_is_copy, chunk_kind,
             chunk_fill, chunk_stream, last_chunk, rejected,
      output ready
   );
endinterface
`default_nettype wire

>>> rtl/bbts_ctrl.sv
// Controller: accepts a request, then steps the datapath one chunk at a time.
`default_nettype none
module bbts_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire bbts_pkg::status_type status,
   output bbts_pkg::cmd_type         cmd
);
   import bbts_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WORK = 2'b10
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (status.nothing_left) begin
               state_in = ST_IDLE;
            end else if (status.slot_free) begin
               cmd.emit = 1'b1;
               if (status.chunk_last) state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> $past(state_ff) != ST_WORK || $past(state_in) == ST_IDLE)
      else $error("request loaded while a request was still in work");

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.slot_free && !status.nothing_left)
      else $error("chunk emitted into a busy output slot");

   a_last_ends_work: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && status.chunk_last |=> state_ff == ST_IDLE)
      else $error("controller kept working after the last chunk");

endmodule
`default_nettype wire

>>> rtl/bbts_datapath.sv
// Datapath: working addresses, remaining length, chunk sizing and the output word register.
`default_nettype none
module bbts_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bbts_pkg::cmd_type             cmd,
   output bbts_pkg::status_type               status,
   input  wire logic                          req_type,
   input  wire logic [bbts_pkg::KIND_W-1:0]   copy_kind,
   input  wire logic [bbts_pkg::ADDR_W-1:0]   dest_addr,
   input  wire logic [bbts_pkg::ADDR_W-1:0]   source_addr,
   input  wire logic [bbts_pkg::LEN_W-1:0]    byte_length,
   input  wire logic [bbts_pkg::BYTE_W-1:0]   fill_byte,
   input  wire logic [bbts_pkg::BYTE_W-1:0]   stream_tag,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [bbts_pkg::ADDR_W-1:0]        chunk_dest,
   output logic [bbts_pkg::ADDR_W-1:0]        chunk_source,
   output logic [bbts_pkg::LEN_W-1:0]         chunk_length,
   output logic                               chunk_is_copy,
   output logic [bbts_pkg::KIND_W-1:0]        chunk_kind,
   output logic [bbts_pkg::BYTE_W-1:0]        chunk_fill,
   output logic [bbts_pkg::BYTE_W-1:0]        chunk_stream,
   output logic                               last_chunk,
   output logic                               rejected
);
   import bbts_pkg::*;

   // working request
   logic [ADDR_W-1:0] cur_dest_ff, cur_source_ff;
   logic [LEN_W-1:0]  bytes_left_ff;
   mode_type          mode_ff;
   logic              dev_src_ff;
   logic              is_copy_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [BYTE_W-1:0] fill_ff, stream_ff;

   // output word
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] o_dest_ff, o_source_ff;
   logic [LEN_W-1:0]  o_len_ff;
   logic              o_copy_ff, o_last_ff, o_rej_ff;
   logic [KIND_W-1:0] o_kind_ff;
   logic [BYTE_W-1:0] o_fill_ff, o_stream_ff;

   mode_type          mode_in;
   logic [ROOM_W-1:0] room_dest, room_src, room_dev;
   logic [LEN_W-1:0]  room_both, room_sel, cnt;
   logic              chunk_last, chunk_rej;

   always_comb begin
      if (byte_length > LEN_W'(MAX_LENGTH)) begin
         mode_in = MODE_REJECT;
      end else if (req_type == REQ_COPY && copy_kind == KIND_HOST_HOST) begin
         mode_in = MODE_WHOLE;
      end else if (req_type == REQ_COPY &&
                   (copy_kind == KIND_DEV_DEV || copy_kind == KIND_DEFAULT)) begin
         mode_in = MODE_BOTH;
      end else begin
         mode_in = MODE_DEV;
      end
   end

   assign room_dest = ROOM_W'(BLOCK_SIZE) - {1'b0, cur_dest_ff[OFS_W-1:0]};
   assign room_src  = ROOM_W'(BLOCK_SIZE) - {1'b0, cur_source_ff[OFS_W-1:0]};
   assign room_dev  = dev_src_ff ? room_src : room_dest;
   assign room_both = (room_dest < room_src) ? LEN_W'(room_dest) : LEN_W'(room_src);
   assign room_sel  = (mode_ff == MODE_BOTH) ? room_both : LEN_W'(room_dev);

   always_comb begin
      cnt        = '0;
      chunk_last = 1'b1;
      chunk_rej  = 1'b0;
      case (mode_ff)
         MODE_REJECT: begin
            chunk_rej = 1'b1;
         end
         MODE_WHOLE: begin
            cnt = bytes_left_ff;
         end
         MODE_BOTH, MODE_DEV: begin
            cnt        = (bytes_left_ff < room_sel) ? bytes_left_ff : room_sel;
            chunk_last = (bytes_left_ff == cnt);
         end
         default: begin
            cnt = '0;
         end
      endcase
   end

   // zero-length device split sends nothing
   assign status.nothing_left = (mode_ff == MODE_DEV) && (bytes_left_ff == '0);
   assign status.chunk_last   = chunk_last;
   assign status.slot_free    = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_dest_ff   <= dest_addr;
         cur_source_ff <= source_addr;
         bytes_left_ff <= byte_length;
         mode_ff       <= mode_in;
         dev_src_ff    <= (req_type == REQ_COPY) && (copy_kind == KIND_DEV_HOST);
         is_copy_ff    <= req_type;
         kind_ff       <= copy_kind;
         fill_ff       <= fill_byte;
         stream_ff     <= stream_tag;
      end else if (cmd.emit) begin
         cur_dest_ff   <= cur_dest_ff + ADDR_W'(cnt);
         cur_source_ff <= cur_source_ff + ADDR_W'(cnt);
         bytes_left_ff <= bytes_left_ff - cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         o_dest_ff   <= cur_dest_ff;
         o_source_ff <= is_copy_ff ? cur_source_ff : '0;
         o_len_ff    <= cnt;
         o_copy_ff   <= is_copy_ff;
         o_kind_ff   <= is_copy_ff ? kind_ff : '0;
         o_fill_ff   <= is_copy_ff ? '0 : fill_ff;
         o_stream_ff <= stream_ff;
         o_last_ff   <= chunk_last;
         o_rej_ff    <= chunk_rej;
      end
   end

   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign chunk_dest    = o_dest_ff;
   assign chunk_source  = o_source_ff;
   assign chunk_length  = o_len_ff;
   assign chunk_is_copy = o_copy_ff;
   assign chunk_kind    = o_kind_ff;
   assign chunk_fill    = o_fill_ff;
   assign chunk_stream  = o_stream_ff;
   assign last_chunk    = o_last_ff;
   assign rejected      = o_rej_ff;

   a_reject_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_rej_ff |-> o_last_ff && o_len_ff == '0)
      else $error("rejected word is not a lone empty last word");

   a_chunk_in_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !(o_copy_ff && o_kind_ff == KIND_HOST_HOST)
      |-> o_len_ff <= LEN_W'(BLOCK_SIZE))
      else $error("chunk longer than one block");

   a_emit_advances: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !chunk_last |=> bytes_left_ff != '0)
      else $error("non-final chunk consumed all remaining bytes");

endmodule
`default_nettype wire

>>> rtl/block_boundary_transfer_splitter.sv
// Throughput: one chunk word per cycle while the response side is ready; a new request
// is accepted only when the controller has returned to idle after its current request.
// A zero-length fill produces no chunk word.
// Reset (synchronous, active high) returns the controller to idle and drops rsp valid.
`default_nettype none
module block_boundary_transfer_splitter (
   input  wire logic  clock,
   input  wire logic  reset,
   bbts_req_if.sink   req_chan,
   bbts_rsp_if.source rsp_chan
);
   import bbts_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   bbts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   bbts_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_type      (req_chan.req_type),
      .copy_kind     (req_chan.copy_kind),
      .dest_addr     (req_chan.dest_addr),
      .source_addr   (req_chan.source_addr),
      .byte_length   (req_chan.byte_length),
      .fill_byte     (req_chan.fill_byte),
      .stream_tag    (req_chan.stream_tag),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .chunk_dest    (rsp_chan.chunk_dest),
      .chunk_source  (rsp_chan.chunk_source),
      .chunk_length  (rsp_chan.chunk_length),
      .chunk_is_copy (rsp_chan.chunk_is_copy),
      .chunk_kind    (rsp_chan.chunk_kind),
      .chunk_fill    (rsp_chan.chunk_fill),
      .chunk_stream  (rsp_chan.chunk_stream),
      .last_chunk    (rsp_chan.last_chunk),
      .rejected      (rsp_chan.rejected)
   );

endmodule
`default_nettype wire
